[rtl/core/arp_pkg.sv]
// Shared types, constants and byte-layout functions for the ARP request responder.
// Used by arp_rx_parser, arp_reply_tx and arp_request_responder; no dependencies.
`default_nettype none

package arp_pkg;

  localparam logic [15:0] TYPE_ARP       = 16'h0806;
  localparam logic [15:0] TYPE_IPV4      = 16'h0800;
  localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
  localparam logic [15:0] OP_REQUEST     = 16'h0001;
  localparam logic [15:0] OP_REPLY       = 16'h0002;
  localparam logic [7:0]  MAC_ADDR_LEN   = 8'd6;
  localparam logic [7:0]  IP_ADDR_LEN    = 8'd4;

  localparam int          NUM_LOCAL_IP   = 4;
  localparam int          CFG_WIDTH      = 48;
  localparam logic [5:0]  FRAME_LEN      = 6'd42;
  localparam logic [5:0]  LAST_POS       = 6'd41;

  // Byte offsets inside the ARP frame
  localparam logic [5:0] POS_SRC_MAC  = 6'd6;
  localparam logic [5:0] POS_SRC_END  = 6'd11;
  localparam logic [5:0] POS_HDR      = 6'd12;
  localparam logic [5:0] POS_HDR_END  = 6'd21;
  localparam logic [5:0] POS_SHA      = 6'd22;
  localparam logic [5:0] POS_SHA_END  = 6'd27;
  localparam logic [5:0] POS_SPA      = 6'd28;
  localparam logic [5:0] POS_SPA_END  = 6'd31;
  localparam logic [5:0] POS_THA      = 6'd32;
  localparam logic [5:0] POS_THA_END  = 6'd37;
  localparam logic [5:0] POS_TPA      = 6'd38;
  localparam logic [5:0] POS_TPA_END  = 6'd41;

  typedef enum logic [2:0] {
    REG_OWN_MAC     = 3'd0,
    REG_GATEWAY_MAC = 3'd1,
    REG_IP_COUNT    = 3'd2,
    REG_LOCAL_IP_0  = 3'd3,
    REG_LOCAL_IP_1  = 3'd4,
    REG_LOCAL_IP_2  = 3'd5,
    REG_LOCAL_IP_3  = 3'd6
  } cfg_reg_t;

  // Match settings seen by the parser
  typedef struct packed {
    logic [47:0]                   gateway_mac;
    logic [2:0]                    ip_count;
    logic [NUM_LOCAL_IP-1:0][31:0] local_ip;
  } match_cfg_t;

  // Fields captured from a qualifying request, as placed in the reply
  typedef struct packed {
    logic [47:0] peer_mac;   // requester MAC: reply destination and target MAC
    logic [31:0] our_ip;     // requested IP: reply sender IP
    logic [31:0] peer_ip;    // requester IP: reply target IP
  } reply_info_t;

  // Expected request byte at header positions 12..21
  function automatic logic [7:0] hdr_byte(logic [5:0] pos);
    logic [7:0] b;
    case (pos)
      6'd12:   b = TYPE_ARP[15:8];
      6'd13:   b = TYPE_ARP[7:0];
      6'd14:   b = HW_TYPE_ETH[15:8];
      6'd15:   b = HW_TYPE_ETH[7:0];
      6'd16:   b = TYPE_IPV4[15:8];
      6'd17:   b = TYPE_IPV4[7:0];
      6'd18:   b = MAC_ADDR_LEN;
      6'd19:   b = IP_ADDR_LEN;
      6'd20:   b = OP_REQUEST[15:8];
      6'd21:   b = OP_REQUEST[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Byte k of a MAC, first wire byte in the MSBs
  function automatic logic [7:0] mac_byte(logic [47:0] mac, logic [2:0] k);
    logic [47:0] sh;
    sh = mac >> (6'd40 - {k, 3'b000});
    return sh[7:0];
  endfunction

  // Byte k of an IPv4 address, first wire byte in the MSBs
  function automatic logic [7:0] ip_byte(logic [31:0] ip, logic [1:0] k);
    logic [31:0] sh;
    sh = ip >> (5'd24 - {k, 3'b000});
    return sh[7:0];
  endfunction

  // Byte idx of the reply frame
  function automatic logic [7:0] reply_byte(logic [5:0] idx, reply_info_t r,
                                            logic [47:0] own_mac);
    logic [5:0] d;
    logic [7:0] b;
    d = 6'd0;
    b = 8'h00;
    case (idx) inside
      [6'd0:6'd5]:           b = mac_byte(r.peer_mac, idx[2:0]);
      [POS_SRC_MAC:POS_SRC_END]: begin
        d = idx - POS_SRC_MAC;
        b = mac_byte(own_mac, d[2:0]);
      end
      [POS_HDR:6'd20]:       b = hdr_byte(idx);
      POS_HDR_END:           b = OP_REPLY[7:0];
      [POS_SHA:POS_SHA_END]: begin
        d = idx - POS_SHA;
        b = mac_byte(own_mac, d[2:0]);
      end
      [POS_SPA:POS_SPA_END]: begin
        d = idx - POS_SPA;
        b = ip_byte(r.our_ip, d[1:0]);
      end
      [POS_THA:POS_THA_END]: begin
        d = idx - POS_THA;
        b = mac_byte(r.peer_mac, d[2:0]);
      end
      [POS_TPA:POS_TPA_END]: begin
        d = idx - POS_TPA;
        b = ip_byte(r.peer_ip, d[1:0]);
      end
      default:               b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/core/arp_rx_parser.sv]
// Receive-side parser: captures request fields byte by byte and qualifies the frame.
// Depends on arp_pkg.
`default_nettype none

module arp_rx_parser (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic [7:0]           frame_byte,
  input  wire logic                 frame_end,
  input  wire arp_pkg::match_cfg_t  cfg,
  output logic                      reply_vld,
  output arp_pkg::reply_info_t      reply_info
);

  logic [5:0]  pos_r,     pos_nxt;
  logic        hdr_ok_r,  hdr_ok_nxt;
  logic [47:0] src_mac_r, src_mac_nxt;
  logic [47:0] sha_r,     sha_nxt;
  logic [31:0] spa_r,     spa_nxt;
  logic [31:0] tpa_r,     tpa_nxt;
  logic [arp_pkg::NUM_LOCAL_IP-1:0] ip_hit;
  logic        qualifies;

  // Capture fields of the current word
  always_comb begin
    src_mac_nxt = src_mac_r;
    hdr_ok_nxt  = hdr_ok_r;
    sha_nxt     = sha_r;
    spa_nxt     = spa_r;
    tpa_nxt     = tpa_r;
    case (pos_r) inside
      [arp_pkg::POS_SRC_MAC:arp_pkg::POS_SRC_END]:
        src_mac_nxt = {src_mac_r[39:0], frame_byte};
      [arp_pkg::POS_HDR:arp_pkg::POS_HDR_END]:
        if (frame_byte != arp_pkg::hdr_byte(pos_r)) hdr_ok_nxt = 1'b0;
      [arp_pkg::POS_SHA:arp_pkg::POS_SHA_END]:
        sha_nxt = {sha_r[39:0], frame_byte};
      [arp_pkg::POS_SPA:arp_pkg::POS_SPA_END]:
        spa_nxt = {spa_r[23:0], frame_byte};
      [arp_pkg::POS_TPA:arp_pkg::POS_TPA_END]:
        tpa_nxt = {tpa_r[23:0], frame_byte};
      default: ;
    endcase
    // Saturate at the frame length
    pos_nxt = (pos_r < arp_pkg::FRAME_LEN) ? pos_r + 6'd1 : pos_r;
  end

  // Count above four behaves as four
  always_comb begin
    for (int i = 0; i < arp_pkg::NUM_LOCAL_IP; i++) begin
      ip_hit[i] = (cfg.ip_count > 3'(i)) && (cfg.local_ip[i] == tpa_nxt);
    end
  end

  assign qualifies = (pos_nxt >= arp_pkg::FRAME_LEN) && hdr_ok_nxt &&
                     (sha_nxt == src_mac_nxt) && (sha_nxt == cfg.gateway_mac) &&
                     (|ip_hit);

  assign reply_vld           = accept && frame_end && qualifies;
  assign reply_info.peer_mac = sha_nxt;
  assign reply_info.our_ip   = tpa_nxt;
  assign reply_info.peer_ip  = spa_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hdr_ok_r  <= 1'b1;
      src_mac_r <= '0;
      sha_r     <= '0;
      spa_r     <= '0;
      tpa_r     <= '0;
    end else if (accept) begin
      if (frame_end) begin
        // Return to the start-of-frame state
        pos_r     <= '0;
        hdr_ok_r  <= 1'b1;
        src_mac_r <= '0;
        sha_r     <= '0;
        spa_r     <= '0;
        tpa_r     <= '0;
      end else begin
        pos_r     <= pos_nxt;
        hdr_ok_r  <= hdr_ok_nxt;
        src_mac_r <= src_mac_nxt;
        sha_r     <= sha_nxt;
        spa_r     <= spa_nxt;
        tpa_r     <= tpa_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/arp_reply_tx.sv]
// Reply transmitter: one pending reply slot, a byte sequencer and the output register.
// Depends on arp_pkg.
`default_nettype none

module arp_reply_tx (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  reply_vld,
  input  wire arp_pkg::reply_info_t  reply_info,
  input  wire logic [47:0]           own_mac,
  output logic                       pend_full,
  output logic                       out_vld,
  output logic [7:0]                 out_byte,
  output logic                       out_end,
  input  wire logic                  out_rdy
);

  logic                 pend_vld_r, pend_vld_nxt;
  arp_pkg::reply_info_t pend_r;
  logic                 act_r, act_nxt;
  arp_pkg::reply_info_t act_info_r;
  logic [5:0]           idx_r, idx_nxt;
  logic                 ovld_r, ovld_nxt;
  logic [7:0]           obyte_r;
  logic                 oend_r;
  logic                 take_pend;
  logic                 emit;

  // Refill the sequencer on the last byte of a reply so replies leave back to back
  assign take_pend = pend_vld_r && (!act_r || (emit && idx_r == arp_pkg::LAST_POS));
  assign emit      = act_r && (!ovld_r || out_rdy);

  always_comb begin
    pend_vld_nxt = pend_vld_r;
    if (reply_vld)      pend_vld_nxt = 1'b1;
    else if (take_pend) pend_vld_nxt = 1'b0;

    act_nxt = act_r;
    idx_nxt = idx_r;
    if (take_pend) begin
      act_nxt = 1'b1;
      idx_nxt = '0;
    end else if (emit) begin
      idx_nxt = idx_r + 6'd1;
      if (idx_r == arp_pkg::LAST_POS) act_nxt = 1'b0;
    end

    ovld_nxt = ovld_r;
    if (emit)         ovld_nxt = 1'b1;
    else if (out_rdy) ovld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      act_r      <= 1'b0;
      idx_r      <= '0;
      ovld_r     <= 1'b0;
    end else begin
      pend_vld_r <= pend_vld_nxt;
      act_r      <= act_nxt;
      idx_r      <= idx_nxt;
      ovld_r     <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (reply_vld) pend_r <= reply_info;
    if (take_pend) act_info_r <= pend_r;
    if (emit) begin
      obyte_r <= arp_pkg::reply_byte(idx_r, act_info_r, own_mac);
      oend_r  <= (idx_r == arp_pkg::LAST_POS);
    end
  end

  // The slot frees in the same cycle its reply moves to the sequencer
  assign pend_full = pend_vld_r && !take_pend;
  assign out_vld   = ovld_r;
  assign out_byte  = obyte_r;
  assign out_end   = oend_r;

endmodule

`default_nettype wire

[rtl/core/arp_request_responder.sv]
// Top level of the ARP request responder: configuration registers, parser and transmitter.
// Depends on arp_pkg, arp_rx_parser and arp_reply_tx.
`default_nettype none

//  channel | direction | word
//  in_     | slave     | one received frame byte, tlast on the last byte
//  out_    | master    | one reply byte, tlast on byte 42 of the reply
//  cfg_    | write     | register index and data, no read-back
//
// One frame byte is taken per cycle while in_tready holds. A qualifying request is
// answered with 42 reply bytes, passed from the pending slot through the sequencer to
// the output register after its last byte, one byte per cycle while out_tready holds;
// a queued reply follows the one ahead of it with no gap. One reply waits in a pending
// slot while another is sent; in_tready drops only while that slot holds a reply that
// cannot move on this cycle. Synchronous active-low reset clears parser, slot and output.

module arp_request_responder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] frame_byte
  input  wire logic                           in_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] reply_byte
  output logic                                out_tlast,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_addr,
  input  wire logic [arp_pkg::CFG_WIDTH-1:0]  cfg_wdata
);

  logic [47:0]          own_mac_r;
  arp_pkg::match_cfg_t  match_cfg_r;
  logic                 accept;
  logic                 reply_vld;
  arp_pkg::reply_info_t reply_info;
  logic                 pend_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_mac_r   <= '0;
      match_cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        arp_pkg::REG_OWN_MAC:     own_mac_r               <= cfg_wdata[47:0];
        arp_pkg::REG_GATEWAY_MAC: match_cfg_r.gateway_mac <= cfg_wdata[47:0];
        arp_pkg::REG_IP_COUNT:    match_cfg_r.ip_count    <= cfg_wdata[2:0];
        arp_pkg::REG_LOCAL_IP_0:  match_cfg_r.local_ip[0] <= cfg_wdata[31:0];
        arp_pkg::REG_LOCAL_IP_1:  match_cfg_r.local_ip[1] <= cfg_wdata[31:0];
        arp_pkg::REG_LOCAL_IP_2:  match_cfg_r.local_ip[2] <= cfg_wdata[31:0];
        arp_pkg::REG_LOCAL_IP_3:  match_cfg_r.local_ip[3] <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign in_tready = !pend_full;
  assign accept    = in_tvalid && in_tready;

  arp_rx_parser u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .frame_byte (in_tdata),
    .frame_end  (in_tlast),
    .cfg        (match_cfg_r),
    .reply_vld  (reply_vld),
    .reply_info (reply_info)
  );

  arp_reply_tx u_tx (
    .clk        (clk),
    .rst_n      (rst_n),
    .reply_vld  (reply_vld),
    .reply_info (reply_info),
    .own_mac    (own_mac_r),
    .pend_full  (pend_full),
    .out_vld    (out_tvalid),
    .out_byte   (out_tdata),
    .out_end    (out_tlast),
    .out_rdy    (out_tready)
  );

endmodule

`default_nettype wire
